/* hw/rtl/sem_pkg.sv */
// Shared constants and controller/datapath interface types for the Sobel edge block.
`default_nettype none
package sem_pkg;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int FRAME_WIDTH_RESET = 640;
	localparam int FRAME_HEIGHT_RESET = 480;
	localparam int PIX_MAX = 255;
	localparam int CFG_W = 13;
	localparam int ROOT_W = 17;

	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic capture;
		logic update;
		logic square;
		logic root_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic emit;
		logic root_last;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

/* hw/rtl/sem_ctrl.sv */
// Sequencer that steps one request through capture, read, window update, square, root and output load.
`default_nettype none
module sem_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire sem_pkg::sts_t sts,
	output sem_pkg::cmd_t      cmd
);
	import sem_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_SQR  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic [2:0] state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = sts.skip ? ST_IDLE : ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d = sts.emit ? ST_SQR : ST_IDLE;
			end
			ST_SQR: begin
				cmd.square = 1'b1;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_last)
					state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end
endmodule
`default_nettype wire

/* hw/rtl/sem_dp.sv */
// Datapath: line stores, 3x3 window, position counters, gradients and bit-serial root.
`default_nettype none
module sem_dp #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [sem_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      action,
	input  wire logic [7:0]                pixel_value,
	input  wire sem_pkg::cmd_t             cmd,
	output sem_pkg::sts_t                  sts,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     edge_magnitude,
	output logic [9:0]                     out_col,
	output logic [11:0]                    out_row,
	output logic                           frame_last
);
	import sem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
	localparam int PW = WW + 13;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [WW-1:0] w_eff, raw_w;
	logic [12:0] h_eff;

	logic [7:0] mem_u [0:MAX_WIDTH-1];
	logic [7:0] mem_m [0:MAX_WIDTH-1];
	logic [7:0] rd_u_q, rd_m_q, pix_q;
	logic act_q;
	logic [PW-1:0] total_q, pos_q;
	logic [CW-1:0] in_col_q, ocol_q;
	logic [11:0] orow_q;
	logic [7:0] win_q [0:2][0:2];
	logic in_frame, restart;

	logic [ROOT_W-1:0] v_q, bit_q, root_q, trial;
	logic [7:0] mag_q;
	logic [9:0] col_q;
	logic [11:0] row_q;
	logic last_q, is_last;

	assign raw_w = WW'(width_q);
	assign w_eff = (width_q == '0) ? WW'(1) : (raw_w > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : raw_w;
	assign h_eff = (height_q == '0) ? 13'd1 :
		(height_q > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_q;

	assign in_frame = pos_q < total_q;
	assign sts.skip = act_q && in_frame;
	assign sts.emit = pos_q >= (PW'(w_eff) + PW'(1));
	assign sts.root_last = bit_q[0];
	assign sts.out_free = !out_valid || !out_stall;
	assign is_last = (WW'(ocol_q) + WW'(1) == w_eff) && (13'(orow_q) + 13'd1 == h_eff);
	assign restart = cfg_we || (cmd.load_out && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'(FRAME_WIDTH_RESET);
			height_q <= 13'(FRAME_HEIGHT_RESET);
		end else if (cfg_we) begin
			if (cfg_index == REG_FRAME_WIDTH)
				width_q <= cfg_data[10:0];
			else
				height_q <= cfg_data;
		end
	end

	// line stores; stale contents may be read, but only into taps the zero padding masks
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_u_q <= mem_u[in_col_q];
			rd_m_q <= mem_m[in_col_q];
			pix_q <= pixel_value;
			act_q <= action;
			total_q <= PW'(w_eff * h_eff);
		end
		if (cmd.update) begin
			mem_u[in_col_q] <= rd_m_q;
			mem_m[in_col_q] <= in_frame ? pix_q : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win_q[r][c] <= 8'd0;
		end else if (cmd.update) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rd_u_q;
			win_q[1][2] <= rd_m_q;
			win_q[2][2] <= in_frame ? pix_q : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			in_col_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (restart) begin
			pos_q <= '0;
			in_col_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else begin
			if (cmd.update) begin
				pos_q <= pos_q + PW'(1);
				if (WW'(in_col_q) + WW'(1) >= w_eff)
					in_col_q <= '0;
				else
					in_col_q <= in_col_q + CW'(1);
			end
			if (cmd.load_out) begin
				if (WW'(ocol_q) + WW'(1) == w_eff) begin
					ocol_q <= '0;
					orow_q <= orow_q + 12'd1;
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
			end
		end
	end

	// gradients with zero padding, clamped to 0..255
	logic vr0, vr2, vc0, vc2;
	logic [7:0] p [0:2][0:2];
	logic signed [11:0] gx, gy;
	logic [7:0] ux, uy;

	assign vr0 = orow_q != '0;
	assign vr2 = (13'(orow_q) + 13'd1) < h_eff;
	assign vc0 = ocol_q != '0;
	assign vc2 = (WW'(ocol_q) + WW'(1)) < w_eff;

	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				p[r][c] = ((r == 0 && !vr0) || (r == 2 && !vr2) ||
					(c == 0 && !vc0) || (c == 2 && !vc2)) ? 8'd0 : win_q[r][c];
		gx = (12'(p[0][2]) + (12'(p[1][2]) << 1) + 12'(p[2][2])) -
			(12'(p[0][0]) + (12'(p[1][0]) << 1) + 12'(p[2][0]));
		gy = (12'(p[2][0]) + (12'(p[2][1]) << 1) + 12'(p[2][2])) -
			(12'(p[0][0]) + (12'(p[0][1]) << 1) + 12'(p[0][2]));
		ux = gx[11] ? 8'd0 : (gx > 12'sd255) ? 8'd255 : gx[7:0];
		uy = gy[11] ? 8'd0 : (gy > 12'sd255) ? 8'd255 : gy[7:0];
	end

	assign trial = root_q + bit_q;

	// one result bit per cycle, from bit 8 down to bit 0
	always_ff @(posedge clk) begin
		if (cmd.square) begin
			v_q <= ROOT_W'(16'(ux * ux)) + ROOT_W'(16'(uy * uy));
			root_q <= '0;
			bit_q <= ROOT_W'(1) << (ROOT_W - 1);
		end else if (cmd.root_step) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mag_q <= (root_q > ROOT_W'(PIX_MAX)) ? 8'(PIX_MAX) : root_q[7:0];
			col_q <= 10'(ocol_q);
			row_q <= orow_q;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.load_out)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	assign edge_magnitude = mag_q;
	assign out_col = col_q;
	assign out_row = row_q;
	assign frame_last = last_q;
endmodule
`default_nettype wire

/* hw/rtl/sobel_edge_magnitude.sv */
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Pixels arrive in raster order on the input channel (in_valid/in_stall):
// action 0 carries a pixel, action 1 is a flush tick. After the last pixel
// of a frame, width+1 flush ticks drain the trailing outputs.
// Each output pixel appears on the output channel (out_valid/out_stall)
// with its column, row and a frame_last mark on the final pixel.
// One request is in flight at a time: capture and line-store read, window
// update, gradient square, then a bit-serial square root and the output load.
// A request that yields no output ends after the window update, and a
// flush tick ignored inside the frame ends after the line-store read.
// The output register holds a result while the receiver stalls; the block
// then waits before loading the next result, while requests that yield no
// output keep flowing until then. Reset clears the sequencer, position
// counters and window and sets width 640, height 480; the line stores need
// no clearing pass. Configuration writes (cfg_we, cfg_index, cfg_data)
// restart the frame.
`default_nettype none
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [sem_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      action,
	input  wire logic [7:0]                pixel_value,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     edge_magnitude,
	output logic [9:0]                     out_col,
	output logic [11:0]                    out_row,
	output logic                           frame_last
);
	import sem_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.pixel_value    (pixel_value),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.edge_magnitude (edge_magnitude),
		.out_col        (out_col),
		.out_row        (out_row),
		.frame_last     (frame_last)
	);
endmodule
`default_nettype wire

/* hw/rtl/sem_check.sv */
// Port-level checker for the Sobel edge block and its bind to the top level.
`default_nettype none
module sem_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  edge_magnitude,
	input wire logic [9:0]  out_col,
	input wire logic [11:0] out_row,
	input wire logic        frame_last
);
	// one request in flight: the cycle after an accept is always stalled
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a request is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(edge_magnitude) && $stable(out_col) &&
			$stable(out_row) && $stable(frame_last))
		else $error("output payload changed while stalled");
endmodule

bind sobel_edge_magnitude sem_check u_sem_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.edge_magnitude (edge_magnitude),
	.out_col        (out_col),
	.out_row        (out_row),
	.frame_last     (frame_last)
);
`default_nettype wire
